@@ design/sfe_pkg.sv @@
// Shared types, constants and the segment lookup for the seven-segment
// frame encoder. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfe_pkg;

  localparam int VALUE_W    = 16;
  localparam int DP_W       = 8;
  localparam int FRAME_W    = 16;
  localparam int DIGITS     = 4;
  localparam int MAX_DISPLAY = 9999;

  localparam logic [FRAME_W-1:0] BLANK_FRAME   = 16'h00FF;
  localparam logic [7:0]         DP_CLEAR_MASK = 8'h7F;

  typedef logic [3:0] digit_t;

  // Payload handed from the digit pipeline to the frame serializer.
  typedef struct packed {
    logic                  bank;
    logic [DP_W-1:0]       dp;
    digit_t [DIGITS-1:0]   dig;   // dig[0] is the thousands digit
  } sfe_item_t;

  // Common-anode segment code of one decimal digit; non-decimal codes blank.
  function automatic logic [7:0] seg_of(input digit_t d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ design/sfe_digits.sv @@
// Three-stage decimal digit extraction pipeline: clamp and thousands,
// hundreds, then tens and ones. Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfe_digits (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sfe_pkg::VALUE_W-1:0]   in_value,
  input  wire logic                          in_bank_select,
  input  wire logic [sfe_pkg::DP_W-1:0]      in_dp_position,
  output logic                               dq_valid,
  input  wire logic                          dq_ready,
  output sfe_pkg::sfe_item_t                 dq_item
);
  import sfe_pkg::*;

  // Stage valid bits and per-stage enables
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic en1, en2, en3;

  // Stage 1 payload
  digit_t          s1_th_r;
  logic [9:0]      s1_rem_r;
  logic            s1_bank_r;
  logic [DP_W-1:0] s1_dp_r;

  // Stage 2 payload
  digit_t          s2_th_r, s2_hu_r;
  logic [6:0]      s2_rem_r;
  logic            s2_bank_r;
  logic [DP_W-1:0] s2_dp_r;

  // Stage 3 payload
  sfe_item_t       s3_item_r;

  // Combinational per-stage results
  logic [13:0] vc, th_base;
  digit_t      th_nxt, hu_nxt, te_nxt;
  logic [9:0]  rem1_nxt, hu_base;
  logic [6:0]  rem2_nxt, te_base;
  digit_t      on_nxt;

  // A stage loads when empty or when its contents move on
  assign en3      = !s3_valid_r || dq_ready;
  assign en2      = !s2_valid_r || en3;
  assign en1      = !s1_valid_r || en2;
  assign in_stall = !en1;

  // Clamp and pick the thousands digit by parallel threshold compares
  always_comb begin
    vc      = (in_value > VALUE_W'(MAX_DISPLAY)) ? 14'(MAX_DISPLAY) : in_value[13:0];
    th_nxt  = '0;
    th_base = '0;
    for (int k = 1; k < 10; k++) begin
      if (vc >= 14'(k * 1000)) begin
        th_nxt  = 4'(k);
        th_base = 14'(k * 1000);
      end
    end
    rem1_nxt = 10'(vc - th_base);
  end

  // Hundreds digit from the remainder below one thousand
  always_comb begin
    hu_nxt  = '0;
    hu_base = '0;
    for (int k = 1; k < 10; k++) begin
      if (s1_rem_r >= 10'(k * 100)) begin
        hu_nxt  = 4'(k);
        hu_base = 10'(k * 100);
      end
    end
    rem2_nxt = 7'(s1_rem_r - hu_base);
  end

  // Tens and ones from the remainder below one hundred
  always_comb begin
    te_nxt  = '0;
    te_base = '0;
    for (int k = 1; k < 10; k++) begin
      if (s2_rem_r >= 7'(k * 10)) begin
        te_nxt  = 4'(k);
        te_base = 7'(k * 10);
      end
    end
    on_nxt = 4'(s2_rem_r - te_base);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_valid;
      if (en2) s2_valid_r <= s1_valid_r;
      if (en3) s3_valid_r <= s2_valid_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_th_r   <= th_nxt;
      s1_rem_r  <= rem1_nxt;
      s1_bank_r <= in_bank_select;
      s1_dp_r   <= in_dp_position;
    end
    if (en2) begin
      s2_th_r   <= s1_th_r;
      s2_hu_r   <= hu_nxt;
      s2_rem_r  <= rem2_nxt;
      s2_bank_r <= s1_bank_r;
      s2_dp_r   <= s1_dp_r;
    end
    if (en3) begin
      s3_item_r.bank   <= s2_bank_r;
      s3_item_r.dp     <= s2_dp_r;
      s3_item_r.dig[0] <= s2_th_r;
      s3_item_r.dig[1] <= s2_hu_r;
      s3_item_r.dig[2] <= te_nxt;
      s3_item_r.dig[3] <= on_nxt;
    end
  end

  assign dq_valid = s3_valid_r;
  assign dq_item  = s3_item_r;

endmodule

`default_nettype wire

@@ design/sfe_serial.sv @@
// Frame serializer: turns one digit set into four digit frames and a
// blanking frame on a registered output. Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfe_serial (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          dq_valid,
  output logic                               dq_ready,
  input  wire sfe_pkg::sfe_item_t            dq_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sfe_pkg::FRAME_W-1:0]        out_frame,
  output logic                               out_last
);
  import sfe_pkg::*;

  localparam logic [2:0] LAST_IDX = 3'(DIGITS);

  logic              busy_r;
  logic [2:0]        cnt_r;
  sfe_item_t         item_r;
  logic              out_valid_r, out_last_r;
  logic [FRAME_W-1:0] out_frame_r;

  logic              out_adv;
  logic [2:0]        sel_idx;
  logic [7:0]        sel, seg;
  logic [FRAME_W-1:0] frame_nxt;

  // Output register frees when empty or when its transfer completes
  assign out_adv  = !out_valid_r || !out_stall;
  assign dq_ready = !busy_r || (out_adv && cnt_r == LAST_IDX);

  // Build the frame for the current slot
  always_comb begin
    sel_idx = {item_r.bank, cnt_r[1:0]};
    sel     = 8'b1 << sel_idx;
    seg     = seg_of(item_r.dig[cnt_r[1:0]]);
    if (item_r.dp == DP_W'(cnt_r)) seg = seg & DP_CLEAR_MASK;
    frame_nxt = (cnt_r == LAST_IDX) ? BLANK_FRAME : {sel, seg};
  end

  // Sequence slots and drive the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_adv) out_valid_r <= busy_r;
      // Take a new digit set, else advance or close the current one
      if (dq_valid && dq_ready) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (out_adv && busy_r) begin
        if (cnt_r == LAST_IDX) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_adv && busy_r) begin
      out_frame_r <= frame_nxt;
      out_last_r  <= (cnt_r == LAST_IDX);
    end
    if (dq_valid && dq_ready) item_r <= dq_item;
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

@@ design/seven_segment_frame_encoder.sv @@
// Top level of the seven-segment frame encoder: digit pipeline feeding
// the frame serializer. Depends on sfe_pkg, sfe_digits and sfe_serial.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the input (value, bank select, decimal-point position)
// produces five output transfers: four digit frames, thousands first, each
// with a one-hot digit select in the high byte and the active-low segment
// code in the low byte, then the blanking frame 0x00FF with out_last set.
// Values above 9999 show as 9999; a decimal-point position of 4 or more
// lights no point. The first frame is presented once the digit set has
// passed three digit-extraction stages, the serializer's holding register
// and the output register. The single frame output carries one frame per
// cycle while out_stall is low, so the block sustains one input for every
// five frames; the input side keeps accepting into the pipeline while
// earlier frames wait on out_stall, until its three stages fill.
module seven_segment_frame_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sfe_pkg::VALUE_W-1:0]   in_value,
  input  wire logic                          in_bank_select,
  input  wire logic [sfe_pkg::DP_W-1:0]      in_dp_position,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sfe_pkg::FRAME_W-1:0]        out_frame,
  output logic                               out_last
);
  import sfe_pkg::*;

  logic      dq_valid, dq_ready;
  sfe_item_t dq_item;

  // Extract decimal digits
  sfe_digits u_digits (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_bank_select (in_bank_select),
    .in_dp_position (in_dp_position),
    .dq_valid       (dq_valid),
    .dq_ready       (dq_ready),
    .dq_item        (dq_item)
  );

  // Emit frames
  sfe_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .dq_valid  (dq_valid),
    .dq_ready  (dq_ready),
    .dq_item   (dq_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_frame (out_frame),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

@@ dv/seven_segment_frame_encoder_tb.sv @@
// Self-checking testbench for seven_segment_frame_encoder: directed and random
// display values across four idling phases, with an in-bench frame predictor.
// Depends on sfe_pkg and the seven_segment_frame_encoder RTL.
`timescale 1ns / 1ps

module seven_segment_frame_encoder_tb;

  import sfe_pkg::*;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               last;
  } frame_word_t;

  // Common-anode segment codes, digits 0..9
  localparam logic [7:0] SEGMENT_CODE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  localparam int MAX_REPORTS = 10;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value       = '0;
  logic               in_bank_select = 1'b0;
  logic [DP_W-1:0]    in_dp_position = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [FRAME_W-1:0] out_frame;
  logic               out_last;

  frame_word_t expected_frames[$];
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          items_sent = 0;
  int          frames_seen = 0;
  int          error_count = 0;

  seven_segment_frame_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_bank_select (in_bank_select),
    .in_dp_position (in_dp_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame      (out_frame),
    .out_last       (out_last)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue the five frames one display value produces
  function automatic void encode_frames(input logic [VALUE_W-1:0] value,
                                        input logic bank, input logic [DP_W-1:0] dp);
    int          shown;
    int          digit [DIGITS];
    logic [7:0]  select;
    logic [7:0]  segments;
    frame_word_t word;
    shown    = (value > MAX_DISPLAY) ? MAX_DISPLAY : int'(value);
    digit[0] = shown / 1000;
    digit[1] = (shown % 1000) / 100;
    digit[2] = (shown % 100) / 10;
    digit[3] = shown % 10;
    for (int d = 0; d < DIGITS; d++) begin
      select   = 8'(1 << (int'(bank) * 4 + d));
      segments = SEGMENT_CODE[digit[d]];
      if (int'(dp) == d) segments = segments & DP_CLEAR_MASK;
      word.frame = {select, segments};
      word.last  = 1'b0;
      expected_frames.push_back(word);
    end
    word.frame = BLANK_FRAME;
    word.last  = 1'b1;
    expected_frames.push_back(word);
  endfunction

  // Present one item, hold it until the transfer, then record its frames
  task automatic send_display_item(input logic [VALUE_W-1:0] value, input logic bank,
                                   input logic [DP_W-1:0] dp);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_bank_select <= bank;
    in_dp_position <= dp;
    do @(posedge clk); while (in_stall);
    encode_frames(value, bank, dp);
    items_sent++;
  endtask

  // Check each output transfer against the oldest expected frame; drive stall
  always @(posedge clk) begin
    frame_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      frames_seen++;
      if (expected_frames.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected frame %h last %b", out_frame, out_last);
      end else begin
        want = expected_frames.pop_front();
        if (out_frame !== want.frame || out_last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: frame expected %h last %b, got %h last %b",
                     want.frame, want.last, out_frame, out_last);
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic test_field_extremes();
    send_display_item(16'd0, 1'b0, 8'd0);
    send_display_item(16'd9999, 1'b1, 8'd3);
    send_display_item(16'd1, 1'b1, 8'd0);
    send_display_item(16'd9998, 1'b0, 8'd255);
  endtask

  // Values past 9999 clamp to 9999
  task automatic test_saturation();
    send_display_item(16'd10000, 1'b0, 8'd1);
    send_display_item(16'd65535, 1'b1, 8'd255);
    send_display_item(16'd32768, 1'b0, 8'd2);
    send_display_item(16'd10001, 1'b1, 8'd4);
  endtask

  // Point on each digit, and positions that light none
  task automatic test_decimal_point();
    for (int p = 0; p < DIGITS; p++) send_display_item(16'd8888, p[0], 8'(p));
    send_display_item(16'd4321, 1'b0, 8'd4);
    send_display_item(16'd4321, 1'b1, 8'd128);
    send_display_item(16'd4321, 1'b0, 8'd85);
    send_display_item(16'd4321, 1'b1, 8'd170);
  endtask

  // Each digit 0 to 9 appears in at least one value
  task automatic test_digit_table();
    send_display_item(16'd1234, 1'b0, 8'd4);
    send_display_item(16'd5678, 1'b1, 8'd4);
    send_display_item(16'd9012, 1'b0, 8'd4);
    send_display_item(16'd3456, 1'b1, 8'd4);
    send_display_item(16'd7890, 1'b0, 8'd4);
    send_display_item(16'd2109, 1'b1, 8'd4);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    logic [VALUE_W-1:0] value;
    logic [DP_W-1:0]    dp;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      // Mostly in-range values, some clamped, some full-width noise
      case ($urandom_range(9))
        0:       value = 16'($urandom_range(65535, 10000));
        1:       value = 16'($urandom());
        2:       value = ($urandom_range(1)) ? 16'd9999 : 16'd10000;
        default: value = 16'($urandom_range(MAX_DISPLAY));
      endcase
      case ($urandom_range(9))
        0:       dp = 8'd4;
        1:       dp = 8'($urandom());
        default: dp = 8'($urandom_range(DIGITS - 1));
      endcase
      send_display_item(value, 1'($urandom_range(1)), dp);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_saturation();
    test_decimal_point();
    test_digit_table();
    test_random_traffic(72, 0, 0);
    test_random_traffic(72, 63, 0);
    test_random_traffic(72, 0, 63);
    test_random_traffic(72, 16, 16);

    // Drain outstanding frames, then watch for strays
    in_valid <= 1'b0;
    receiver_stall_pct = 0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    error_count += expected_frames.size();

    $display("Sent %0d display values and checked %0d frames", items_sent, frames_seen);
    $display("Phases: directed, free flow, sender idle, receiver stall, both idling");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard time limit
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
